// ===== src/nnis_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler package
// Shared constants, widths and codes for the scaler and its pixel memory.
// ----------------------------------------------------------------------------
package nnis_pkg;

    localparam int SRC_DEPTH   = 65536;
    localparam int MAX_DST_DIM = 1024;

    localparam int ADDR_W    = $clog2(SRC_DEPTH);
    localparam int PIX_W     = 32;
    localparam int IDX_W     = 20;
    localparam int SRC_DIM_W = 9;
    localparam int DST_DIM_W = 11;
    localparam int ROW_W     = $clog2(MAX_DST_DIM);
    localparam int AREA_W    = 2 * ROW_W + 1;
    localparam int PROD_W    = SRC_DIM_W + ROW_W;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_FETCH = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } t_cfg_reg;

endpackage

// ===== src/nnis_pixel_mem.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler pixel memory
// Single-port source image store with registered read data and a hold enable.
// ----------------------------------------------------------------------------
module nnis_pixel_mem
    import nnis_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [PIX_W-1:0]  i_wdata,
    output logic [PIX_W-1:0]  o_rdata
);

    logic [PIX_W-1:0] r_mem [SRC_DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/nearest_neighbor_image_scaler.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler
// Stores a source image and returns pixels of a scaled destination image.
// ----------------------------------------------------------------------------
// Input words carry a load or a fetch, selected by s_axis_tuser. A load writes
// one source pixel and returns nothing. A fetch returns one word on the master
// side: the source pixel nearest to the destination index, or zero with the
// out-of-range flag set when the index is not below the destination area.
// The configuration port sets the source and destination sizes; the user must
// write it only while no words are in flight; the block does not enforce it.
// A fetch passes in order through a pipelined divider that splits the index
// into row and column, one multiply, two parallel pipelined dividers for the
// source coordinates, one address multiply, the memory read and the output
// register. One word enters per cycle while the receiver does not stall;
// loads travel the same pipeline and write the memory at the read stage, so
// fetches always see the loads accepted before them.
// Reset empties the pipeline and sets all sizes to 256; the pixel memory holds
// whatever it held. When the receiver stalls, the whole pipeline holds and
// s_axis_tready falls until the output word is taken.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler
    import nnis_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // src_address [15:0], pixel_in [47:16], dest_index [67:48], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action [0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_out [31:0]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // out_of_range [0]
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DST_DIM_W-1:0]  i_cfg_wdata
);

    localparam int QA = ROW_W;
    localparam int QB = SRC_DIM_W;

    logic                 adv;
    logic [ADDR_W-1:0]    in_addr;
    logic [PIX_W-1:0]     in_pix;
    logic [IDX_W-1:0]     in_idx;
    t_action              in_act;
    logic                 in_oor;

    logic [SRC_DIM_W-1:0] r_src_w, r_src_h;
    logic [DST_DIM_W-1:0] r_dw, r_dh;
    logic [AREA_W-1:0]    r_area;
    logic [DST_DIM_W-1:0] n_dim;

    // Row and column divider.
    logic                 r_a_v    [QA];
    t_action              r_a_act  [QA];
    logic                 r_a_oor  [QA];
    logic [ADDR_W-1:0]    r_a_addr [QA];
    logic [PIX_W-1:0]     r_a_pix  [QA];
    logic [IDX_W-1:0]     r_a_rem  [QA];
    logic [ROW_W-1:0]     r_a_q    [QA];
    logic [IDX_W-1:0]     n_a_rem  [QA];
    logic [ROW_W-1:0]     n_a_q    [QA];

    // Scale products.
    logic                 r_m_v;
    t_action              r_m_act;
    logic                 r_m_oor;
    logic [ADDR_W-1:0]    r_m_addr;
    logic [PIX_W-1:0]     r_m_pix;
    logic [PROD_W-1:0]    r_m_rp, r_m_cp;

    // Source coordinate dividers.
    logic                 r_b_v     [QB];
    t_action              r_b_act   [QB];
    logic                 r_b_oor   [QB];
    logic [ADDR_W-1:0]    r_b_addr  [QB];
    logic [PIX_W-1:0]     r_b_pix   [QB];
    logic [PROD_W-1:0]    r_b_rrem  [QB];
    logic [PROD_W-1:0]    r_b_crem  [QB];
    logic [SRC_DIM_W-1:0] r_b_rq    [QB];
    logic [SRC_DIM_W-1:0] r_b_cq    [QB];
    logic [PROD_W-1:0]    n_b_rrem  [QB];
    logic [PROD_W-1:0]    n_b_crem  [QB];
    logic [SRC_DIM_W-1:0] n_b_rq    [QB];
    logic [SRC_DIM_W-1:0] n_b_cq    [QB];

    // Address stage, read stage and output.
    logic                 r_x_v;
    t_action              r_x_act;
    logic                 r_x_oor;
    logic [ADDR_W-1:0]    r_x_addr;
    logic [PIX_W-1:0]     r_x_pix;
    logic                 r_r_v;
    t_action              r_r_act;
    logic                 r_r_oor;
    logic [PIX_W-1:0]     mem_rdata;
    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_pix;
    logic                 r_out_oor;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv;

    assign in_addr = s_axis_tdata[15:0];
    assign in_pix  = s_axis_tdata[47:16];
    assign in_idx  = s_axis_tdata[67:48];
    assign in_act  = t_action'(s_axis_tuser);
    assign in_oor  = ({1'b0, in_idx} >= r_area);

    always_comb begin
        n_dim = (i_cfg_wdata > DST_DIM_W'(MAX_DST_DIM)) ? DST_DIM_W'(MAX_DST_DIM)
                                                         : i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_DIM_W'(256);
            r_src_h <= SRC_DIM_W'(256);
            r_dw    <= DST_DIM_W'(256);
            r_dh    <= DST_DIM_W'(256);
            r_area  <= AREA_W'(65536);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SRC_WIDTH:  r_src_w <= i_cfg_wdata[SRC_DIM_W-1:0];
                REG_SRC_HEIGHT: r_src_h <= i_cfg_wdata[SRC_DIM_W-1:0];
                REG_DST_WIDTH: begin
                    r_dw   <= n_dim;
                    r_area <= AREA_W'(n_dim) * AREA_W'(r_dh);
                end
                REG_DST_HEIGHT: begin
                    r_dh   <= n_dim;
                    r_area <= AREA_W'(r_dw) * AREA_W'(n_dim);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [IDX_W-1:0] rem;
        logic [ROW_W-1:0] q;
        logic [IDX_W-1:0] trial;
        for (int k = 0; k < QA; k++) begin
            rem   = (k == 0) ? in_idx : r_a_rem[(k == 0) ? 0 : k - 1];
            q     = (k == 0) ? '0 : r_a_q[(k == 0) ? 0 : k - 1];
            trial = IDX_W'(r_dw) << (QA - 1 - k);
            n_a_rem[k] = (rem >= trial) ? rem - trial : rem;
            n_a_q[k]   = q;
            n_a_q[k][QA-1-k] = (rem >= trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QA; k++) begin
                r_a_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_a_v[0] <= s_axis_tvalid;
            for (int k = 1; k < QA; k++) begin
                r_a_v[k] <= r_a_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_act[0]  <= in_act;
            r_a_oor[0]  <= in_oor;
            r_a_addr[0] <= in_addr;
            r_a_pix[0]  <= in_pix;
            for (int k = 1; k < QA; k++) begin
                r_a_act[k]  <= r_a_act[k-1];
                r_a_oor[k]  <= r_a_oor[k-1];
                r_a_addr[k] <= r_a_addr[k-1];
                r_a_pix[k]  <= r_a_pix[k-1];
            end
            for (int k = 0; k < QA; k++) begin
                r_a_rem[k] <= n_a_rem[k];
                r_a_q[k]   <= n_a_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (adv) begin
            r_m_v <= r_a_v[QA-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_act  <= r_a_act[QA-1];
            r_m_oor  <= r_a_oor[QA-1];
            r_m_addr <= r_a_addr[QA-1];
            r_m_pix  <= r_a_pix[QA-1];
            r_m_rp   <= PROD_W'(r_src_h) * PROD_W'(r_a_q[QA-1]);
            r_m_cp   <= PROD_W'(r_src_w) * PROD_W'(r_a_rem[QA-1][ROW_W-1:0]);
        end
    end

    always_comb begin
        logic [PROD_W-1:0]    rr, cr, tr, tc;
        logic [SRC_DIM_W-1:0] rq, cq;
        for (int k = 0; k < QB; k++) begin
            rr = (k == 0) ? r_m_rp : r_b_rrem[(k == 0) ? 0 : k - 1];
            cr = (k == 0) ? r_m_cp : r_b_crem[(k == 0) ? 0 : k - 1];
            rq = (k == 0) ? '0 : r_b_rq[(k == 0) ? 0 : k - 1];
            cq = (k == 0) ? '0 : r_b_cq[(k == 0) ? 0 : k - 1];
            tr = PROD_W'(r_dh) << (QB - 1 - k);
            tc = PROD_W'(r_dw) << (QB - 1 - k);
            n_b_rrem[k] = (rr >= tr) ? rr - tr : rr;
            n_b_crem[k] = (cr >= tc) ? cr - tc : cr;
            n_b_rq[k]   = rq;
            n_b_cq[k]   = cq;
            n_b_rq[k][QB-1-k] = (rr >= tr);
            n_b_cq[k][QB-1-k] = (cr >= tc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QB; k++) begin
                r_b_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r_b_v[0] <= r_m_v;
            for (int k = 1; k < QB; k++) begin
                r_b_v[k] <= r_b_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_act[0]  <= r_m_act;
            r_b_oor[0]  <= r_m_oor;
            r_b_addr[0] <= r_m_addr;
            r_b_pix[0]  <= r_m_pix;
            for (int k = 1; k < QB; k++) begin
                r_b_act[k]  <= r_b_act[k-1];
                r_b_oor[k]  <= r_b_oor[k-1];
                r_b_addr[k] <= r_b_addr[k-1];
                r_b_pix[k]  <= r_b_pix[k-1];
            end
            for (int k = 0; k < QB; k++) begin
                r_b_rrem[k] <= n_b_rrem[k];
                r_b_crem[k] <= n_b_crem[k];
                r_b_rq[k]   <= n_b_rq[k];
                r_b_cq[k]   <= n_b_cq[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
            r_r_v <= 1'b0;
        end else if (adv) begin
            r_x_v <= r_b_v[QB-1];
            r_r_v <= r_x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x_act <= r_b_act[QB-1];
            r_x_oor <= r_b_oor[QB-1];
            r_x_pix <= r_b_pix[QB-1];
            if (r_b_act[QB-1] == ACT_LOAD) begin
                r_x_addr <= r_b_addr[QB-1];
            end else begin
                r_x_addr <= ADDR_W'(r_b_rq[QB-1]) * ADDR_W'(r_src_w)
                            + ADDR_W'(r_b_cq[QB-1]);
            end
            r_r_act <= r_x_act;
            r_r_oor <= r_x_oor;
        end
    end

    nnis_pixel_mem u_mem (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_we    (r_x_v && (r_x_act == ACT_LOAD)),
        .i_addr  (r_x_addr),
        .i_wdata (r_x_pix),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_r_v && (r_r_act == ACT_FETCH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pix <= r_r_oor ? '0 : mem_rdata;
            r_out_oor <= r_r_oor;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tuser  = r_out_oor;

    a_oor_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_oor |-> r_out_pix == '0)
        else $error("out-of-range word carries a nonzero pixel");

    a_col_below_width : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v[QA-1] && (r_a_act[QA-1] == ACT_FETCH) && !r_a_oor[QA-1]
        |-> r_a_rem[QA-1] < IDX_W'(r_dw))
        else $error("column remainder not below destination width");

    a_row_below_height : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v[QA-1] && (r_a_act[QA-1] == ACT_FETCH) && !r_a_oor[QA-1]
        |-> ROW_W'(r_a_q[QA-1]) < r_dh)
        else $error("row quotient not below destination height");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_x_addr) && $stable(r_r_v))
        else $error("pipeline moved during a stall");

endmodule
